// ===== design/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Depends on nothing; each macro takes its clock and reset explicitly.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== design/csb_pkg.sv =====
// Shared types and constants for the counting semaphore bank.
// Used by the store, exec and top-level design files and by the checker; depends on nothing.
package csb_pkg;

   localparam int DEFAULT_SEM_ENTRIES = 16;
   localparam int COUNT_W = 15;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [1:0] {
      OP_INIT = 2'd0,
      OP_WAIT = 2'd1,
      OP_POST = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_ERROR = 2'd1,
      ST_BLOCK = 2'd2
   } status_type;

   typedef struct packed {
      logic               en;
      logic [COUNT_W-1:0] value;
   } cnt_wr_type;

endpackage

// ===== design/csb_store.sv =====
// Semaphore storage: valid bit per entry in flops, counts in a memory with
// registered read and write-to-read forwarding. Depends on csb_pkg.
module csb_store #(
   parameter int SEM_ENTRIES = csb_pkg::DEFAULT_SEM_ENTRIES,
   parameter int IDX_W       = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [IDX_W-1:0]            rd_idx,
   input  csb_pkg::cnt_wr_type         wr,
   input  logic [IDX_W-1:0]            wr_idx,
   input  logic [IDX_W-1:0]            valid_idx,
   output logic                        valid_out,
   output logic [csb_pkg::COUNT_W-1:0] count_out
);

   logic [SEM_ENTRIES-1:0]         valid_ff;
   logic [csb_pkg::COUNT_W-1:0]    mem [SEM_ENTRIES];
   logic [csb_pkg::COUNT_W-1:0]    rd_data_ff;
   logic [csb_pkg::COUNT_W-1:0]    fwd_data_ff;
   logic                           fwd_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_idx] <= wr.value;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_idx];
         fwd_data_ff <= wr.value;
      end
   end

   // forward a same-cycle write to the entry being read
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_hit_ff <= wr.en && (wr_idx == rd_idx);
      end
   end

   assign valid_out = valid_ff[valid_idx];
   assign count_out = fwd_hit_ff ? fwd_data_ff : rd_data_ff;

endmodule

// ===== design/csb_exec.sv =====
// Operation logic for one request: init, wait or post against one entry.
// Combinational; depends on csb_pkg.
module csb_exec (
   input  logic [1:0]                  func,
   input  logic                        in_range,
   input  logic                        entry_valid,
   input  logic [csb_pkg::COUNT_W-1:0] count,
   input  logic [15:0]                 init_value,
   output csb_pkg::status_type         status,
   output logic                        wake,
   output logic [csb_pkg::COUNT_W-1:0] count_after,
   output csb_pkg::cnt_wr_type         wr
);

   logic known;

   always_comb begin
      known       = in_range && entry_valid;
      status      = csb_pkg::ST_ERROR;
      wake        = 1'b0;
      count_after = '0;
      wr.en       = 1'b0;
      wr.value    = init_value[csb_pkg::COUNT_W-1:0];
      if (in_range) begin
         case (func)
            csb_pkg::OP_INIT: begin
               if (!init_value[15]) begin
                  wr.en       = 1'b1;
                  status      = csb_pkg::ST_DONE;
                  count_after = init_value[csb_pkg::COUNT_W-1:0];
               end
            end
            csb_pkg::OP_WAIT: begin
               wr.value = count - 1'b1;
               if (known) begin
                  if (count == '0) begin
                     status = csb_pkg::ST_BLOCK;
                  end else begin
                     wr.en       = 1'b1;
                     status      = csb_pkg::ST_DONE;
                     count_after = wr.value;
                  end
               end
            end
            csb_pkg::OP_POST: begin
               wr.value = count + 1'b1;
               if (known && count != csb_pkg::COUNT_MAX) begin
                  wr.en       = 1'b1;
                  wake        = 1'b1;
                  status      = csb_pkg::ST_DONE;
                  count_after = wr.value;
               end
            end
            default: begin
               status = csb_pkg::ST_ERROR;
            end
         endcase
      end
   end

endmodule

// ===== design/counting_semaphore_bank_unit.sv =====
// An accepted request moves from the stage register to the response register.
// Throughput: one request per cycle unless the response stalls; the stage register
// and response register each hold one request; the count memory reads once a cycle.
// Reset clears all valid bits and empties both registers; counts stay
// undefined until an init writes them.
module counting_semaphore_bank_unit #(
   parameter int SEM_ENTRIES = csb_pkg::DEFAULT_SEM_ENTRIES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [1:0] func, [9:2] sem_id, [25:10] init_value, [31:26] zero
   input  logic [csb_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [1:0] status, [2] wake, [17:3] count_after, [23:18] zero
   output logic [csb_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IDX_W = (SEM_ENTRIES > 1) ? $clog2(SEM_ENTRIES) : 1;
   localparam logic [8:0] ENTRIES_L = 9'(SEM_ENTRIES);
   localparam int PAD_W = csb_pkg::RSP_DATA_W - 3 - csb_pkg::COUNT_W;

   logic                           stg_valid_ff, stg_valid_in;
   logic [1:0]                     stg_func_ff;
   logic [7:0]                     stg_id_ff;
   logic [15:0]                    stg_init_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [csb_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                           req_accept;
   logic                           stg_advance;
   logic                           in_range;
   logic                           entry_valid;
   logic [csb_pkg::COUNT_W-1:0]    count;
   csb_pkg::status_type            status;
   logic                           wake;
   logic [csb_pkg::COUNT_W-1:0]    count_after;
   csb_pkg::cnt_wr_type            exec_wr;
   csb_pkg::cnt_wr_type            cnt_wr;

   assign stg_advance  = stg_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !stg_valid_ff || stg_advance;
   assign req_accept   = req_tvalid && req_tready;
   assign stg_valid_in = req_accept || (stg_valid_ff && !stg_advance);
   assign rsp_valid_in = stg_advance || (rsp_valid_ff && !rsp_tready);
   assign in_range     = {1'b0, stg_id_ff} < ENTRIES_L;

   assign cnt_wr.en    = exec_wr.en && stg_advance;
   assign cnt_wr.value = exec_wr.value;

   assign rsp_data_in  = {{PAD_W{1'b0}}, count_after, wake, 2'(status)};

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stg_func_ff <= req_tdata[1:0];
         stg_id_ff   <= req_tdata[9:2];
         stg_init_ff <= req_tdata[25:10];
      end
      if (stg_advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   csb_store #(
      .SEM_ENTRIES (SEM_ENTRIES),
      .IDX_W       (IDX_W)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (req_accept),
      .rd_idx      (req_tdata[2 +: IDX_W]),
      .wr          (cnt_wr),
      .wr_idx      (stg_id_ff[IDX_W-1:0]),
      .valid_idx   (stg_id_ff[IDX_W-1:0]),
      .valid_out   (entry_valid),
      .count_out   (count)
   );

   csb_exec u_exec (
      .func        (stg_func_ff),
      .in_range    (in_range),
      .entry_valid (entry_valid),
      .count       (count),
      .init_value  (stg_init_ff),
      .status      (status),
      .wake        (wake),
      .count_after (count_after),
      .wr          (exec_wr)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== design/csb_checker.sv =====
// Port-level checker for the semaphore bank, bound to the top level.
// Depends on csb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module csb_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [csb_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic [1:0]                  rsp_status;
   logic                        rsp_wake;
   logic [csb_pkg::COUNT_W-1:0] rsp_count;
   logic                        rsp_done;
   logic                        rsp_stall;

   assign rsp_status = rsp_tdata[1:0];
   assign rsp_wake   = rsp_tdata[2];
   assign rsp_count  = rsp_tdata[17:3];
   assign rsp_done   = rsp_status == csb_pkg::ST_DONE;
   assign rsp_stall  = rsp_tvalid && !rsp_tready;

   `ASSERT_CLK(a_wake_done, clock, reset, rsp_tvalid && rsp_wake |-> rsp_done, "wake not done")
   `ASSERT_CLK(a_fail_zero, clock, reset, rsp_tvalid && !rsp_done |-> rsp_count == '0, "fail count")
   `ASSERT_NEVER(a_bad_status, clock, reset, rsp_tvalid && rsp_status > csb_pkg::ST_BLOCK, "status")
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata), "hold")
   `ASSERT_CLK(a_req_ready, clock, reset, !rsp_tvalid |-> req_tready, "request stalled while empty")

endmodule

bind counting_semaphore_bank_unit csb_checker u_csb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
